FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/nms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types and constants for 3x3 peak detection with sub-pixel refinement.
// ----------------------------------------------------------------------------
package nms_pkg;
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned FW_W      = 11;
  localparam int unsigned SUM_W     = 18;
  localparam int unsigned REM_W     = 19;
  localparam int unsigned SROW_W    = 20;
  localparam int unsigned SCOL_W    = 18;
  localparam int unsigned STEP_W    = 3;
  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FW_W-1:0] FW_MIN   = 11'd3;
  localparam logic [FW_W-1:0] FW_MAX   = 11'd1024;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_EVAL, ST_DIV, ST_FIN, ST_OUT
  } nms_state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic eval;
    logic step;
    logic finish;
  } nms_cmd_t;

  typedef struct packed {
    logic judge;
    logic is_max;
    logic div_done;
  } nms_stat_t;
endpackage
`default_nettype wire

FILE: rtl/nms_3x3_subpixel_peaks.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nms_3x3_subpixel_peaks
// 3x3 strict non-maximum suppression with Q8 sub-pixel peak refinement.
// ----------------------------------------------------------------------------
// Input channel: pixel_score/start_of_frame with in_valid; the block drives
// in_stall. Pixels arrive in raster order; start_of_frame marks row 0, col 0.
// Output channel: one item per interior centre (row >= 1, col >= 1), given
// when the pixel one row below and one column right has been taken; the
// downstream side stalls with out_stall and the item holds until taken.
// Per pixel: ST_IDLE accepts it and ST_SHIFT writes the single-ported line
// stores; a judged centre runs ST_EVAL, ST_DIV, ST_FIN and ST_OUT, which
// holds through any output stall. A peak runs the 8-step restoring dividers
// (row and column divide in parallel, one quotient bit per cycle).
// frame_width is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while idle, as the block does not enforce it. Values are clamped to
// 3..1024. Reset (rst, synchronous) clears the counters, window and
// sequencer and sets frame_width to 640. Line stores are not cleared; the
// first two rows of a frame fill them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module nms_3x3_subpixel_peaks (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [nms_pkg::FW_W-1:0]   cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [nms_pkg::PIX_W-1:0]  pixel_score,
  input  wire logic                       start_of_frame,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [nms_pkg::ROW_W-1:0]       center_row,
  output logic [nms_pkg::COL_W-1:0]       center_col,
  output logic                            is_maximum,
  output logic [nms_pkg::SROW_W-1:0]      sub_row_q8,
  output logic [nms_pkg::SCOL_W-1:0]      sub_col_q8
);
  import nms_pkg::*;

  nms_cmd_t  cmd;
  nms_stat_t stat;

  nms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  nms_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .pixel_score    (pixel_score),
    .start_of_frame (start_of_frame),
    .center_row     (center_row),
    .center_col     (center_col),
    .is_maximum     (is_maximum),
    .sub_row_q8     (sub_row_q8),
    .sub_col_q8     (sub_col_q8)
  );

  `ASSERT_IMPLIES(a_one_item, clk, rst, !in_stall, !out_valid)
  `ASSERT_IMPLIES(a_nonpeak_zero, clk, rst, out_valid && !is_maximum,
                  sub_row_q8 == '0 && sub_col_q8 == '0)
  `ASSERT_IMPLIES(a_interior, clk, rst, out_valid, center_col != '0 && center_row != '0)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire

FILE: rtl/nms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nms_ctrl
// Sequencer: accept, shift window, evaluate, divide, present result.
// ----------------------------------------------------------------------------
module nms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire nms_pkg::nms_stat_t stat,
  output nms_pkg::nms_cmd_t      cmd
);
  import nms_pkg::*;

  nms_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = stat.judge ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.is_max) begin
          state_next = ST_FIN;
        end else begin
          cmd.step = 1'b1;
          if (stat.div_done) state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/nms_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nms_dp
// Line stores, 3x3 window, position counters, two radix-2 dividers and
// the result register.
// ----------------------------------------------------------------------------
module nms_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire nms_pkg::nms_cmd_t         cmd,
  output nms_pkg::nms_stat_t             stat,
  input  wire logic                      cfg_wr_en,
  input  wire logic [nms_pkg::FW_W-1:0]  cfg_wr_data,
  input  wire logic [nms_pkg::PIX_W-1:0] pixel_score,
  input  wire logic                      start_of_frame,
  output logic [nms_pkg::ROW_W-1:0]      center_row,
  output logic [nms_pkg::COL_W-1:0]      center_col,
  output logic                           is_maximum,
  output logic [nms_pkg::SROW_W-1:0]     sub_row_q8,
  output logic [nms_pkg::SCOL_W-1:0]     sub_col_q8
);
  import nms_pkg::*;

  logic [FW_W-1:0]  frame_width;
  logic [FW_W-1:0]  weff;
  logic [COL_W-1:0] column_count, col_sel, col_r;
  logic [ROW_W-1:0] row_count, row_sel, row_r;
  logic [FW_W-1:0]  col_inc;
  logic [PIX_W-1:0] pix_r, up1, up2;
  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  logic             mx, is_max_r;
  logic [REM_W-1:0] rem_r, rem_c, rem2_r, rem2_c;
  logic [SUM_W-1:0] sum_r, sum_c;
  logic             neg_r, neg_c;
  logic [FRAC_W-1:0] q_r, q_c;
  logic [STEP_W-1:0] step;
  logic [SROW_W-1:0] base_r;
  logic [SCOL_W-1:0] base_c;
  logic [ROW_W-1:0] crow;
  logic [COL_W-1:0] ccol;

  always_comb begin
    if (frame_width < FW_MIN)      weff = FW_MIN;
    else if (frame_width > FW_MAX) weff = FW_MAX;
    else                           weff = frame_width;
  end

  assign col_sel = start_of_frame ? '0 : column_count;
  assign row_sel = start_of_frame ? '0 : row_count;
  assign col_inc = {1'b0, col_sel} + FW_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (cfg_wr_en) frame_width <= cfg_wr_data;
      if (cmd.load) begin
        if (col_inc >= weff) begin
          column_count <= '0;
          row_count    <= row_sel + ROW_W'(1);
        end else begin
          column_count <= col_inc[COL_W-1:0];
          row_count    <= row_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= pixel_score;
      col_r <= col_sel;
      row_r <= row_sel;
      up1   <= mem_a[col_sel];
      up2   <= mem_b[col_sel];
    end
    if (cmd.shift) begin
      mem_a[col_r] <= pix_r;
      mem_b[col_r] <= up1;
    end
  end

  // win[3*r + c]: r 0 = top row, c 2 = newest column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win[3*k]   <= win[3*k+1];
        win[3*k+1] <= win[3*k+2];
      end
      win[2] <= up2;
      win[5] <= up1;
      win[8] <= pix_r;
    end
  end

  always_comb begin
    mx = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && win[k] >= win[4]) mx = 1'b0;
    end
  end

  // |next - prev| < sum for a peak, so the quotient fits FRAC_W bits
  assign rem2_r = {rem_r[REM_W-2:0], 1'b0};
  assign rem2_c = {rem_c[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      is_max_r <= mx;
      neg_r    <= win[7] < win[1];
      neg_c    <= win[5] < win[3];
      rem_r    <= REM_W'((win[7] < win[1]) ? win[1] - win[7] : win[7] - win[1]);
      rem_c    <= REM_W'((win[5] < win[3]) ? win[3] - win[5] : win[5] - win[3]);
      sum_r    <= SUM_W'(win[1]) + SUM_W'(win[4]) + SUM_W'(win[7]);
      sum_c    <= SUM_W'(win[3]) + SUM_W'(win[4]) + SUM_W'(win[5]);
      q_r      <= '0;
      q_c      <= '0;
      step     <= '0;
    end else if (cmd.step) begin
      if (rem2_r >= {1'b0, sum_r}) begin
        rem_r <= rem2_r - {1'b0, sum_r};
        q_r   <= {q_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2_r;
        q_r   <= {q_r[FRAC_W-2:0], 1'b0};
      end
      if (rem2_c >= {1'b0, sum_c}) begin
        rem_c <= rem2_c - {1'b0, sum_c};
        q_c   <= {q_c[FRAC_W-2:0], 1'b1};
      end else begin
        rem_c <= rem2_c;
        q_c   <= {q_c[FRAC_W-2:0], 1'b0};
      end
      step <= step + STEP_W'(1);
    end
  end

  assign crow   = row_r - ROW_W'(1);
  assign ccol   = col_r - COL_W'(1);
  assign base_r = {crow, {FRAC_W{1'b0}}} + SROW_W'(1 << (FRAC_W - 1));
  assign base_c = {ccol, {FRAC_W{1'b0}}} + SCOL_W'(1 << (FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      center_row <= crow;
      center_col <= ccol;
      is_maximum <= is_max_r;
      if (is_max_r) begin
        sub_row_q8 <= neg_r ? base_r - SROW_W'(q_r) : base_r + SROW_W'(q_r);
        sub_col_q8 <= neg_c ? base_c - SCOL_W'(q_c) : base_c + SCOL_W'(q_c);
      end else begin
        sub_row_q8 <= '0;
        sub_col_q8 <= '0;
      end
    end
  end

  assign stat.judge    = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign stat.is_max   = is_max_r;
  assign stat.div_done = (step == STEP_LAST);
endmodule
`default_nettype wire

FILE: bench/nms_3x3_subpixel_peaks_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_3x3_subpixel_peaks_test
// Self-checking bench for 3x3 peak detection with sub-pixel refinement.
// Streams raster frames at several small widths (clamped writes at both
// ends, a mid-row width change), predicts every judged centre and
// compares each output item field by field, with random input idling and
// output back-pressure.
// ----------------------------------------------------------------------------
module nms_3x3_subpixel_peaks_test;
  import nms_pkg::*;

  localparam int GUARD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              peak;
    logic [SROW_W-1:0] srow;
    logic [SCOL_W-1:0] scol;
  } centre_t;

  class peak_scoreboard;
    int unsigned       width_eff;
    logic [PIX_W-1:0]  prev_row [MAX_WIDTH];
    logic [PIX_W-1:0]  prev_row2 [MAX_WIDTH];
    logic [PIX_W-1:0]  win [9];
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    centre_t           pending [$];
    int                errors;
    int                pixels;
    int                judged;
    int                peaks;

    function new();
      width_eff = FW_RESET;
      foreach (prev_row[i]) begin
        prev_row[i] = '0;
        prev_row2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
      pixels = 0;
      judged = 0;
      peaks = 0;
    endfunction

    function void set_width(logic [FW_W-1:0] w);
      width_eff = (w < FW_MIN) ? FW_MIN : (w > FW_MAX) ? FW_MAX : w;
    endfunction

    function longint refine(int unsigned idx, logic [PIX_W-1:0] prv,
                            logic [PIX_W-1:0] mid, logic [PIX_W-1:0] nxt);
      longint sum, diff, q, base;
      sum = longint'(prv) + longint'(mid) + longint'(nxt);
      diff = (longint'(nxt) - longint'(prv)) * (longint'(1) << FRAC_W);
      q = (sum > 0) ? diff / sum : 0;
      base = (longint'(idx) << FRAC_W) + (longint'(1) << (FRAC_W - 1)) + q;
      return (base < 0) ? 0 : base;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic sof);
      int unsigned col, row;
      logic [PIX_W-1:0] up1, up2, mid;
      centre_t c;
      pixels++;
      if (sof) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      col = col_cnt;
      row = row_cnt;
      up1 = '0;
      up2 = '0;
      if (col < MAX_WIDTH) begin
        up1 = prev_row[col];
        up2 = prev_row2[col];
        prev_row2[col] = up1;
        prev_row[col] = pix;
      end
      for (int k = 0; k < 3; k++) begin
        win[3*k] = win[3*k+1];
        win[3*k+1] = win[3*k+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = pix;
      if (row >= 2 && col >= 2) begin
        mid = win[4];
        c.peak = 1'b1;
        for (int k = 0; k < 9; k++)
          if (k != 4 && win[k] >= mid) c.peak = 1'b0;
        c.row = ROW_W'(row - 1);
        c.col = COL_W'(col - 1);
        c.srow = '0;
        c.scol = '0;
        if (c.peak) begin
          c.srow = SROW_W'(refine(row - 1, win[1], mid, win[7]));
          c.scol = SCOL_W'(refine(col - 1, win[3], mid, win[5]));
        end
        pending = {pending, c};
      end
      col_cnt = col + 1;
      if (col_cnt >= width_eff) begin
        col_cnt = 0;
        row_cnt = (row + 1) % 4096;
      end
    endfunction

    function void check_result(centre_t got);
      centre_t exp_c;
      if (pending.size() == 0) begin
        $error("output item with nothing pending: row %0d col %0d", got.row, got.col);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      judged++;
      if (got.peak) peaks++;
      if (got.row !== exp_c.row) begin
        $error("center_row expected %0d got %0d", exp_c.row, got.row);
        errors++;
      end
      if (got.col !== exp_c.col) begin
        $error("center_col expected %0d got %0d", exp_c.col, got.col);
        errors++;
      end
      if (got.peak !== exp_c.peak) begin
        $error("is_maximum expected %0d got %0d", exp_c.peak, got.peak);
        errors++;
      end
      if (got.srow !== exp_c.srow) begin
        $error("sub_row_q8 expected %0d got %0d", exp_c.srow, got.srow);
        errors++;
      end
      if (got.scol !== exp_c.scol) begin
        $error("sub_col_q8 expected %0d got %0d", exp_c.scol, got.scol);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [FW_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] pixel_score = '0;
  logic start_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] center_row;
  logic [COL_W-1:0] center_col;
  logic is_maximum;
  logic [SROW_W-1:0] sub_row_q8;
  logic [SCOL_W-1:0] sub_col_q8;

  peak_scoreboard sb = new();
  bit calm = 1'b0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic [PIX_W-1:0] tile [9];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nms_3x3_subpixel_peaks DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_score(pixel_score), .start_of_frame(start_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .center_row(center_row), .center_col(center_col),
    .is_maximum(is_maximum), .sub_row_q8(sub_row_q8), .sub_col_q8(sub_col_q8)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall)
        sb.check_result('{center_row, center_col, is_maximum, sub_row_q8, sub_col_q8});
      if (quiet_cycles >= GUARD_CYCLES) begin
        $display("watchdog: no handshake for %0d cycles", GUARD_CYCLES);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_px(input logic [PIX_W-1:0] p, input logic sof);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_score <= p;
    start_of_frame <= sof;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p, sof);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [FW_W-1:0] w);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_width(w);
  endtask

  function automatic logic [PIX_W-1:0] gen_pixel(int mode);
    case (mode)
      0: return PIX_W'($urandom);
      1: return PIX_W'($urandom_range(0, 3));
      default: return ($urandom_range(0, 9) == 0) ? PIX_W'($urandom)
                                                  : PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_rows(int rows, int cols, int tail, bit sof, int mode);
    for (int i = 0; i < rows * cols + tail; i++)
      send_px(gen_pixel((mode < 0) ? $urandom_range(0, 2) : mode), sof && i == 0);
  endtask

  task automatic send_tile();
    for (int i = 0; i < 9; i++) send_px(tile[i], i == 0);
  endtask

  initial begin
    int w;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset width: a short first row at 640, nothing judged
    calm = 1'b1;
    send_rows(0, 640, 40, 1'b1, 0);

    // below-range write clamps to 3: single-centre frames
    write_width(11'd1);
    calm = 1'b0;
    tile = '{16'd100, 16'd200, 16'd300, 16'd400, 16'hFFFF, 16'd0, 16'hFFFE, 16'd7, 16'd1};
    send_tile();
    tile = '{default: 16'd0};
    send_tile();
    // tie with the left neighbour only
    tile = '{16'd0, 16'd0, 16'd0, 16'd9, 16'd9, 16'd0, 16'd0, 16'd0, 16'd0};
    send_tile();

    // random frames at small widths
    for (int f = 0; f < 18; f++) begin
      write_width(FW_W'($urandom_range(0, 12)));
      calm = ($urandom_range(0, 3) == 0);
      w = sb.width_eff;
      send_rows($urandom_range(3, 6), w, $urandom_range(0, w), 1'b1, -1);
    end

    // shrink the width mid-row, counting continues without a frame start
    write_width(11'd8);
    calm = 1'b0;
    send_rows(3, 8, 5, 1'b1, 2);
    write_width(11'd4);
    send_rows(3, 4, 0, 1'b0, 0);

    // above-range write clamps to the maximum width: a partial first row
    write_width(11'h7FF);
    send_rows(0, MAX_WIDTH, 64, 1'b1, 2);

    drain();
    if (sb.pending.size() != 0) begin
      $error("%0d expected items never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("run: %0d pixels in, %0d centres judged, %0d of them peaks", sb.pixels,
             sb.judged, sb.peaks);
    $display("run: widths 3..12 with clamped writes, a mid-row shrink, stalls on both sides");
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: nms_3x3_subpixel_peaks.f
+incdir+rtl
rtl/nms_pkg.sv
rtl/nms_ctrl.sv
rtl/nms_dp.sv
rtl/nms_3x3_subpixel_peaks.sv
bench/nms_3x3_subpixel_peaks_test.sv
